### hdl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg: shared types, constants and functions of the UTF-8 to UTF-16
// transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

	localparam logic [15:0] REPLACEMENT_CHAR = 16'hFFFD;
	localparam logic [15:0] HIGH_SURR_BASE   = 16'hD800;
	localparam logic [15:0] LOW_SURR_BASE    = 16'hDC00;
	localparam logic [31:0] SUPPLEMENT_BASE  = 32'h0001_0000;
	localparam int unsigned MAX_UNITS        = 3;

	typedef logic [1:0] unit_cnt_t;

	// Code units produced by one byte, packed from slot 0 upward.
	typedef struct packed {
		unit_cnt_t                       count;
		logic [MAX_UNITS-1:0][15:0]      units;
		logic                            eos;
	} unit_group_t;

	// Result of finishing one symbol.
	typedef struct packed {
		logic        pair;
		logic [15:0] hi;
		logic [15:0] lo;
	} finish_t;

	// Payload bits carried by a lead byte 0xC0..0xFF.
	function automatic logic [4:0] lead_payload(input logic [5:0] idx);
		logic [4:0] r;
		r = 5'd0;
		if (idx[5] == 1'b0) begin
			r = idx[4:0];
		end else if (idx[4] == 1'b0) begin
			r = {1'b0, idx[3:0]};
		end else if (idx[3] == 1'b0) begin
			r = {2'b00, idx[2:0]};
		end else if (idx[2] == 1'b0) begin
			r = {3'b000, idx[1:0]};
		end else if (idx[1] == 1'b0) begin
			r = {4'b0000, idx[0]};
		end
		return r;
	endfunction

	// Validate a finished symbol and split it into code units.
	function automatic finish_t finish_symbol(input logic [31:0] acc);
		finish_t     f;
		logic [31:0] v;
		logic [19:0] d;
		v = acc;
		if (v[31:7] == 25'd0 || v[31:11] == 21'h00001B || v[31:1] == 31'h0000_7FFF) begin
			v = {16'd0, REPLACEMENT_CHAR};
		end
		d      = v[19:0] - SUPPLEMENT_BASE[19:0];
		f.pair = (v[31:16] != 16'd0);
		if (f.pair) begin
			f.hi = HIGH_SURR_BASE + {6'd0, d[19:10]};
			f.lo = LOW_SURR_BASE + {6'd0, d[9:0]};
		end else begin
			f.hi = v[15:0];
			f.lo = 16'd0;
		end
		return f;
	endfunction

endpackage

### hdl/u8u16_if.sv
// ----------------------------------------------------------------------------
// u8u16 channels: valid/ready interfaces for the byte input and the code unit
// output.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_byte;

	modport source (output valid, output in_byte, output last_byte, input ready);
	modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface u8u16_unit_if;
	logic        valid;
	logic        ready;
	logic [15:0] code_unit;
	logic        last_of_run;
	logic        end_of_string;

	modport source (output valid, output code_unit, output last_of_run,
		output end_of_string, input ready);
	modport sink   (input valid, input code_unit, input last_of_run,
		input end_of_string, output ready);
endinterface

### hdl/utf8_to_utf16_transcoder.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder: lenient UTF-8 byte stream to UTF-16 code units
// Path: a byte is registered in the input stage, then decoded into the unit buffer.
// Throughput: one byte per cycle while each byte yields at most one unit and
//   the output is not stalled; a byte yielding n > 1 units holds the input stage
//   until the single output port drains the unit buffer to its last unit.
// Reset: arst_n clears the stage valid, the unit buffer count and the symbol state.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
	input  logic         clk,
	input  logic         arst_n,
	u8u16_byte_if.sink   bytes,
	u8u16_unit_if.source units
);
	import u8u16_pkg::*;

	// Input stage: one registered byte transaction.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Symbol state, updated when the staged byte moves into the unit buffer.
	logic        open_q;
	logic [31:0] acc_q;

	// Unit buffer: slot 0 is presented; pops shift the rest down.
	logic [MAX_UNITS-1:0][15:0] unit_q;
	unit_cnt_t                  cnt_q;
	logic                       eos_q;

	unit_group_t grp;
	logic        open_nxt;
	logic [31:0] acc_nxt;
	logic        pop;
	logic        load;
	logic        take;

	u8u16_decode u_decode (
		.open_q    (open_q),
		.acc_q     (acc_q),
		.in_byte   (byte_s1),
		.last_byte (last_s1),
		.grp       (grp),
		.open_nxt  (open_nxt),
		.acc_nxt   (acc_nxt)
	);

	// Output side: a unit leaves on every completed transaction.
	assign pop = units.valid && units.ready;

	// Load the next group when the buffer is empty or gives up its last unit.
	assign load = valid_s1 && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop));

	// Accept a byte whenever the stage is free or moves on this cycle.
	assign bytes.ready = !valid_s1 || load;
	assign take        = bytes.valid && bytes.ready;

	assign units.valid         = (cnt_q != 2'd0);
	assign units.code_unit     = unit_q[0];
	assign units.last_of_run   = (cnt_q == 2'd1);
	assign units.end_of_string = (cnt_q == 2'd1) && eos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage: hold until a new transaction arrives.
	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= bytes.in_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			acc_q  <= '0;
			cnt_q  <= '0;
		end else if (load) begin
			open_q <= open_nxt;
			acc_q  <= acc_nxt;
			cnt_q  <= grp.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			unit_q <= grp.units;
			eos_q  <= grp.eos;
		end else if (pop) begin
			// advance the remaining units toward the port
			unit_q <= {16'd0, unit_q[MAX_UNITS-1:1]};
		end
	end

endmodule

### hdl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode: decode one byte against the symbol state
// Produces the group of code units caused by the byte and the next state.
// ----------------------------------------------------------------------------
module u8u16_decode (
	input  logic                   open_q,
	input  logic [31:0]            acc_q,
	input  logic [7:0]             in_byte,
	input  logic                   last_byte,
	output u8u16_pkg::unit_group_t grp,
	output logic                   open_nxt,
	output logic [31:0]            acc_nxt
);
	import u8u16_pkg::*;

	logic        is_cont;
	logic        is_lead;
	logic [31:0] acc_ext;
	logic [31:0] acc_lead;
	finish_t     fin_old;
	finish_t     fin_ext;
	finish_t     fin_lead;

	assign is_cont  = (in_byte[7:6] == 2'b10);
	assign is_lead  = (in_byte[7:6] == 2'b11);
	assign acc_ext  = {acc_q[25:0], in_byte[5:0]};
	assign acc_lead = {27'd0, lead_payload(in_byte[5:0])};
	assign fin_old  = finish_symbol(acc_q);
	assign fin_ext  = finish_symbol(acc_ext);
	assign fin_lead = finish_symbol(acc_lead);

	always_comb begin
		logic [MAX_UNITS-1:0][15:0] u;
		unit_cnt_t                  n;
		u        = '0;
		n        = '0;
		open_nxt = open_q;
		acc_nxt  = acc_q;
		if (open_q && is_cont) begin
			// extend the open symbol; finish it only at end of string
			acc_nxt = acc_ext;
			if (last_byte) begin
				u[n] = fin_ext.hi;
				n    = n + 2'd1;
				if (fin_ext.pair) begin
					u[n] = fin_ext.lo;
					n    = n + 2'd1;
				end
				open_nxt = 1'b0;
				acc_nxt  = '0;
			end
		end else begin
			if (open_q) begin
				u[n] = fin_old.hi;
				n    = n + 2'd1;
				if (fin_old.pair) begin
					u[n] = fin_old.lo;
					n    = n + 2'd1;
				end
			end
			if (is_lead) begin
				if (last_byte) begin
					u[n]     = fin_lead.hi;
					n        = n + 2'd1;
					open_nxt = 1'b0;
					acc_nxt  = '0;
				end else begin
					open_nxt = 1'b1;
					acc_nxt  = acc_lead;
				end
			end else begin
				u[n]     = {8'd0, in_byte};
				n        = n + 2'd1;
				open_nxt = 1'b0;
				acc_nxt  = '0;
			end
		end
		grp.units = u;
		grp.count = n;
		grp.eos   = last_byte;
	end

endmodule

### hdl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker: port-level assertions for the transcoder
// Attached to every instance of the top level through a bind.
// ----------------------------------------------------------------------------
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] code_unit,
	input logic        last_of_run,
	input logic        end_of_string
);

	// A stalled unit holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit))
		else $error("code unit changed while stalled");

	// End of string only marks the final unit of a run.
	a_eos_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_of_string |-> last_of_run)
		else $error("end_of_string without last_of_run");

	// The units of one run follow back to back.
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |=> out_valid)
		else $error("gap inside a run");

	// The unit after a surrogate high half within a run carries the low half.
	a_surr_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && code_unit[15:10] == 6'b110110 && !last_of_run
		|=> code_unit[15:10] == 6'b110111)
		else $error("high surrogate not followed by low surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (units.valid),
	.out_ready     (units.ready),
	.code_unit     (units.code_unit),
	.last_of_run   (units.last_of_run),
	.end_of_string (units.end_of_string)
);

### tb/utf8_to_utf16_transcoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_test: self-checking bench for the UTF-8 decoder
// Feeds byte strings through the byte channel and mirrors the lenient decoder
// state in the bench. Each code unit transaction on the output channel is
// checked against the oldest predicted unit. Directed strings cover plain and
// stray bytes, well-formed symbols and malformed input. A long random phase
// mixes well-formed text with noise, with random sender gaps and receiver
// stalls.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_test;
	import u8u16_pkg::*;

	localparam int unsigned RANDOM_BYTES  = 150;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned WATCHDOG_NS   = 2_000_000;

	typedef struct packed {
		logic [15:0] code_unit;
		logic        last_of_run;
		logic        end_of_string;
	} code_unit_t;

	logic clk;
	logic arst_n;

	u8u16_byte_if byte_ch ();
	u8u16_unit_if unit_ch ();

	utf8_to_utf16_transcoder uut (
		.clk    (clk),
		.arst_n (arst_n),
		.bytes  (byte_ch),
		.units  (unit_ch)
	);

	// Mirror of the decoder state: open symbol flag and its accumulated value.
	logic        symbol_pending;
	logic [31:0] symbol_value;

	code_unit_t  units_in_flight[$];  // predicted units not yet seen
	code_unit_t  byte_units[$];       // units caused by the current byte
	logic [7:0]  text[$];             // string being assembled for sending

	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned units_checked;
	int unsigned pairs_seen;
	int unsigned replacements_seen;
	int unsigned mismatches;
	int unsigned burst_left;

	logic sender_idle = 1'b0;
	logic sink_stall  = 1'b0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// ------------------------------------------------------------------
	// Decoder mirror
	// ------------------------------------------------------------------

	// Payload bits seeded by a lead byte: strip the leading one-run.
	function automatic logic [4:0] lead_seed(input logic [7:0] b);
		logic [7:0] off;
		off = 8'h00;
		if (b < 8'hE0) off = b - 8'hC0;
		else if (b < 8'hF0) off = b - 8'hE0;
		else if (b < 8'hF8) off = b - 8'hF0;
		else if (b < 8'hFC) off = b - 8'hF8;
		else if (b < 8'hFE) off = b - 8'hFC;
		return off[4:0];
	endfunction

	function automatic void emit_unit(input logic [15:0] value);
		code_unit_t u;
		u.code_unit     = value;
		u.last_of_run   = 1'b0;
		u.end_of_string = 1'b0;
		byte_units.push_back(u);
	endfunction

	// Close the open symbol: replace bad values, split large ones into a pair.
	function automatic void close_symbol();
		logic [31:0] v;
		logic [31:0] d;
		v = symbol_value;
		if (v < 32'h80 || (v & 32'hFFFF_F800) == 32'hD800 ||
			(v & 32'hFFFF_FFFE) == 32'hFFFE) begin
			v = {16'd0, REPLACEMENT_CHAR};
			replacements_seen++;
		end
		if (v < SUPPLEMENT_BASE) begin
			emit_unit(v[15:0]);
		end else begin
			d = v - SUPPLEMENT_BASE;
			emit_unit(HIGH_SURR_BASE + {6'd0, d[19:10]});
			emit_unit(LOW_SURR_BASE + {6'd0, d[9:0]});
			pairs_seen++;
		end
		symbol_pending = 1'b0;
		symbol_value   = '0;
	endfunction

	// Advance the mirror by one accepted byte and queue the units it causes.
	function automatic void predict_byte(input logic [7:0] b, input logic last);
		code_unit_t tail;
		byte_units.delete();
		if (symbol_pending && b[7:6] == 2'b10) begin
			symbol_value = (symbol_value << 6) + {26'd0, b[5:0]};
		end else begin
			if (symbol_pending) close_symbol();
			if (b >= 8'hC0) begin
				symbol_value   = {27'd0, lead_seed(b)};
				symbol_pending = 1'b1;
			end else begin
				emit_unit({8'h00, b});
			end
		end
		if (last && symbol_pending) close_symbol();
		if (byte_units.size() > 0) begin
			tail = byte_units.pop_back();
			tail.last_of_run   = 1'b1;
			tail.end_of_string = last;
			byte_units.push_back(tail);
			foreach (byte_units[i]) units_in_flight.push_back(byte_units[i]);
		end
	endfunction

	// ------------------------------------------------------------------
	// Byte channel driver
	// ------------------------------------------------------------------

	// Send one byte; between bursts drop valid for a random gap.
	task automatic send_byte(input logic [7:0] b, input logic last);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = sender_idle ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				@(negedge clk);
				byte_ch.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		byte_ch.valid     <= 1'b1;
		byte_ch.in_byte   <= b;
		byte_ch.last_byte <= last;
		// hold until the transaction completes
		do @(posedge clk); while (byte_ch.ready !== 1'b1);
		predict_byte(b, last);
		bytes_sent++;
	endtask

	// Send the assembled text as one string, flagging its final byte.
	task automatic send_text();
		int n;
		n = text.size();
		for (int i = 0; i < n; i++) send_byte(text[i], i == n - 1);
		strings_sent++;
	endtask

	// Pause the sender until every predicted unit has arrived.
	task automatic await_drain();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (units_in_flight.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Code unit receiver and checker
	// ------------------------------------------------------------------

	// When stalls are on, follow a random 16-bit mask, reloaded whenever the phase wraps; mostly ready.
	initial begin : sink_pattern
		logic [15:0] mask;
		int unsigned phase;
		unit_ch.ready = 1'b0;
		mask  = 16'hFFFF;
		phase = 0;
		forever begin
			@(negedge clk);
			if (phase == 0) mask = 16'($urandom | $urandom);
			unit_ch.ready <= sink_stall ? mask[phase] : 1'b1;
			phase = (phase + 1) % 16;
		end
	end

	always @(posedge clk) begin : check_units
		code_unit_t want;
		if (arst_n && unit_ch.valid === 1'b1 && unit_ch.ready === 1'b1) begin
			if (units_in_flight.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("%0t: unexpected code unit %h (last_of_run %b end_of_string %b)",
						$time, unit_ch.code_unit, unit_ch.last_of_run, unit_ch.end_of_string);
			end else begin
				want = units_in_flight.pop_front();
				units_checked++;
				if (want.code_unit !== unit_ch.code_unit ||
					want.last_of_run !== unit_ch.last_of_run ||
					want.end_of_string !== unit_ch.end_of_string) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("%0t: mismatch: expected %h/%b/%b, got %h/%b/%b",
							$time, want.code_unit, want.last_of_run, want.end_of_string,
							unit_ch.code_unit, unit_ch.last_of_run, unit_ch.end_of_string);
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Text builders
	// ------------------------------------------------------------------

	// Append a code point in a fixed-length UTF-8 form, overlong if asked.
	function automatic void put_symbol(input logic [20:0] cp, input int unsigned len);
		case (len)
			1: text.push_back({1'b0, cp[6:0]});
			2: begin
				text.push_back({3'b110, cp[10:6]});
				text.push_back({2'b10, cp[5:0]});
			end
			3: begin
				text.push_back({4'b1110, cp[15:12]});
				text.push_back({2'b10, cp[11:6]});
				text.push_back({2'b10, cp[5:0]});
			end
			default: begin
				text.push_back({5'b11110, cp[20:18]});
				text.push_back({2'b10, cp[17:12]});
				text.push_back({2'b10, cp[11:6]});
				text.push_back({2'b10, cp[5:0]});
			end
		endcase
	endfunction

	function automatic int unsigned natural_len(input logic [20:0] cp);
		if (cp < 21'h80) return 1;
		if (cp < 21'h800) return 2;
		if (cp < 21'h10000) return 3;
		return 4;
	endfunction

	// Append one random symbol: mostly well-formed, the rest noise.
	function automatic void add_random_symbol();
		logic [20:0]  cp;
		logic [7:0]   b;
		int unsigned  pick;
		int unsigned  len;
		pick = $urandom_range(0, 19);
		case (pick)
			0, 1, 2, 3: put_symbol(21'($urandom_range(0, 'h7F)), 1);
			4, 5, 6: put_symbol(21'($urandom_range('h80, 'h7FF)), 2);
			7, 8, 9: put_symbol(21'($urandom_range('h800, 'hFFFF)), 3);
			10, 11: put_symbol(21'($urandom_range('h1_0000, 'h10_FFFF)), 4);
			12: begin
				// edge values: noncharacters, surrogates, range limits
				case ($urandom_range(0, 7))
					0: cp = 21'h7F;
					1: cp = 21'hD800;
					2: cp = 21'hDFFF;
					3: cp = 21'hFFFE;
					4: cp = 21'hFFFF;
					5: cp = 21'h10_FFFF;
					6: cp = 21'h11_0000;
					default: cp = 21'h1F_FFFF;
				endcase
				put_symbol(cp, (cp < 21'h80) ? 2 : natural_len(cp));
			end
			13: begin
				// overlong encoding
				cp  = 21'($urandom_range(0, 'h7FF));
				len = (cp < 21'h80) ? $urandom_range(2, 4) : $urandom_range(3, 4);
				put_symbol(cp, len);
			end
			14, 19: begin
				b = 8'($urandom_range(0, 255));
				text.push_back(b);
			end
			15: begin
				// truncated symbol: drop trailing continuation bytes
				len = $urandom_range(2, 4);
				put_symbol(21'($urandom), len);
				repeat ($urandom_range(1, len - 1)) void'(text.pop_back());
			end
			16: begin
				repeat ($urandom_range(1, 3)) begin
					b = 8'($urandom_range('h80, 'hBF));
					text.push_back(b);
				end
			end
			17: begin
				// long continuation run: let the accumulator wrap
				b = 8'($urandom_range('hF8, 'hFF));
				text.push_back(b);
				repeat ($urandom_range(5, 8)) begin
					b = 8'($urandom_range('h80, 'hBF));
					text.push_back(b);
				end
			end
			default: begin
				b = 8'($urandom_range('hC0, 'hFF));
				text.push_back(b);
			end
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// ASCII extremes and stray continuation bytes pass through as is.
	task automatic test_passthrough();
		text = '{8'h00, 8'h7F, 8'h80, 8'hBF};
		send_text();
	endtask

	// Two-, three- and four-byte symbols; a lead byte as the last byte
	// closes the pending pair and itself, three units from one byte.
	task automatic test_well_formed();
		text = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
			8'hF0, 8'h9F, 8'h98, 8'h80, 8'hC3};
		send_text();
	endtask

	// Lead byte cut short by ASCII, encoded surrogate, overlong below 0x80,
	// and a value past the last plane that gets truncated.
	task automatic test_malformed();
		text = '{8'hC3, 8'h41, 8'hED, 8'hA0, 8'h80, 8'hC1, 8'h81,
			8'hF7, 8'hBF, 8'hBF, 8'hBF};
		send_text();
	endtask

	// Random strings with changing sender and receiver behavior.
	task automatic test_random_strings();
		int unsigned first;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			// switch idling on and off per string so quiet stretches occur too
			sender_idle = ($urandom_range(0, 3) != 0);
			sink_stall  = ($urandom_range(0, 3) != 0);
			text.delete();
			repeat ($urandom_range(1, 6)) add_random_symbol();
			send_text();
			if ($urandom_range(0, 7) == 0) await_drain();
		end
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.in_byte   = 8'h00;
		byte_ch.last_byte = 1'b0;
		symbol_pending    = 1'b0;
		symbol_value      = '0;
		bytes_sent        = 0;
		strings_sent      = 0;
		units_checked     = 0;
		pairs_seen        = 0;
		replacements_seen = 0;
		mismatches        = 0;
		burst_left        = 0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_passthrough();
		test_well_formed();
		await_drain();

		sender_idle = 1'b1;
		sink_stall  = 1'b1;
		test_malformed();
		await_drain();

		test_random_strings();
		await_drain();

		$display("Sent %0d bytes in %0d strings, checked %0d code units.",
			bytes_sent, strings_sent, units_checked);
		$display("Predicted %0d surrogate pairs and %0d replacement characters.",
			pairs_seen, replacements_seen);
		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d failing transactions", mismatches);
			$display("CHECK FAILED");
		end
		$finish;
	end

	initial begin
		#(WATCHDOG_NS);
		$display("Timeout with %0d code units outstanding", units_in_flight.size());
		$display("CHECK FAILED");
		$finish;
	end

endmodule
